### hdl/bstb_pkg.sv
// shared types and constants for the burst scheduled token bucket
package bstb_pkg;

  // default fixed point format and tick rate
  localparam int FRAC_BITS_DEF        = 16;
  localparam int TICKS_PER_SECOND_DEF = 1000;

  // field widths
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int COUNT_W     = 16;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BURST_ENABLE   = 3'd0,
    REG_BURST_INTERVAL = 3'd1,
    REG_BURST_DURATION = 3'd2,
    REG_NORMAL_RATE    = 3'd3,
    REG_BURST_RATE     = 3'd4,
    REG_MAX_BATCH      = 3'd5
  } reg_index_t;

  // request kinds
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_CONSUME = 1'b1;

  // register reset values
  localparam logic [31:0]        BURST_INTERVAL_RST = 32'd1000;
  localparam logic [31:0]        BURST_DURATION_RST = 32'd1000;
  localparam logic [31:0]        NORMAL_RATE_RST    = 32'd65536;
  localparam logic [31:0]        BURST_RATE_RST     = 32'd65536;
  localparam logic [COUNT_W-1:0] MAX_BATCH_RST      = 16'd1;

  // configuration seen by the datapath
  typedef struct packed {
    logic               burst_enable;
    logic [31:0]        burst_interval;
    logic [31:0]        burst_duration;
    logic [31:0]        normal_rate;
    logic [31:0]        burst_rate;
    logic [COUNT_W-1:0] max_batch;
  } cfg_t;

endpackage

### hdl/bstb_req_if.sv
// request channel: tick or consume beats
interface bstb_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bstb_pkg::COUNT_W-1:0] sent_count;

  modport source (output valid, req_type, sent_count, input ready);
  modport sink (input valid, req_type, sent_count, output ready);
endinterface

### hdl/bstb_res_if.sv
// result channel: grant and mode beats
interface bstb_res_if;
  logic                        valid;
  logic                        ready;
  logic [bstb_pkg::COUNT_W-1:0] tokens_ready;
  logic                        in_burst;

  modport source (output valid, tokens_ready, in_burst, input ready);
  modport sink (input valid, tokens_ready, in_burst, output ready);
endinterface

### hdl/bstb_core.sv
// bucket and burst schedule state with the per-beat update logic
module bstb_core #(
  parameter int FRAC_BITS        = bstb_pkg::FRAC_BITS_DEF,
  parameter int TICKS_PER_SECOND = bstb_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         req_type,
  input  logic [bstb_pkg::COUNT_W-1:0] sent_count,
  input  bstb_pkg::cfg_t               cfg,
  output logic [bstb_pkg::COUNT_W-1:0] tokens_ready,
  output logic                         in_burst
);
  import bstb_pkg::*;

  localparam int BW      = COUNT_W + 1 + FRAC_BITS;
  localparam int SW      = ((BW > 32) ? BW : 32) + 1;
  localparam int FB_RAW  = (1 << FRAC_BITS) / TICKS_PER_SECOND;
  localparam int FALLBACK = (FB_RAW == 0) ? 1 : FB_RAW;

  logic [BW-1:0]      bucket_level;
  logic [31:0]        phase_counter;
  logic               burst_active;
  logic               prev_enable;

  logic [BW-1:0]      bucket_level_next;
  logic [31:0]        phase_counter_next;
  logic               burst_active_next;

  logic [31:0]        pc0, pc1, limit;
  logic               ba0, ba1;
  logic [31:0]        rate_sel, rate_eff;
  logic [BW-1:0]      cap, sub, tick_level, cons_level;
  logic [SW-1:0]      sum;
  logic [COUNT_W:0]   whole;

  // burst schedule advance for a tick
  always_comb begin
    pc0 = (!prev_enable && cfg.burst_enable) ? '0 : phase_counter;
    ba0 = (!prev_enable && cfg.burst_enable) ? 1'b0 : burst_active;
    limit = ba0 ? cfg.burst_duration : cfg.burst_interval;
    pc1 = pc0;
    ba1 = 1'b0;
    phase_counter_next = pc0;
    if (cfg.burst_enable) begin
      ba1 = ba0;
      if (pc0 >= limit) begin
        ba1 = !ba0;
        pc1 = '0;
      end
      phase_counter_next = (pc1 == '1) ? pc1 : pc1 + 32'd1;
    end
    burst_active_next = ba1;
  end

  // refill with clamp, or consume with floor at zero
  always_comb begin
    rate_sel   = burst_active_next ? cfg.burst_rate : cfg.normal_rate;
    rate_eff   = (rate_sel == '0) ? 32'(FALLBACK) : rate_sel;
    cap        = BW'({cfg.max_batch, 1'b0}) << FRAC_BITS;
    sum        = SW'(bucket_level) + SW'(rate_eff);
    tick_level = (sum > SW'(cap)) ? cap : BW'(sum);
    sub        = BW'(sent_count) << FRAC_BITS;
    cons_level = (bucket_level > sub) ? bucket_level - sub : '0;
    bucket_level_next = (req_type == REQ_TICK) ? tick_level : cons_level;
  end

  // grant limited to the batch size
  always_comb begin
    whole        = bucket_level_next[BW-1:FRAC_BITS];
    tokens_ready = (whole > (COUNT_W+1)'(cfg.max_batch)) ? cfg.max_batch
                                                          : whole[COUNT_W-1:0];
    in_burst     = (req_type == REQ_TICK) ? burst_active_next : burst_active;
  end

  // state update per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_level  <= '0;
      phase_counter <= '0;
      burst_active  <= 1'b0;
      prev_enable   <= 1'b0;
    end else if (step) begin
      bucket_level <= bucket_level_next;
      if (req_type == REQ_TICK) begin
        phase_counter <= phase_counter_next;
        burst_active  <= burst_active_next;
        prev_enable   <= cfg.burst_enable;
      end
    end
  end

endmodule

### hdl/burst_scheduled_token_bucket.sv
// token bucket rate limiter with burst schedule, top level
//
//   channel | dir | payload                  | beat taken when
//   req     | in  | req_type, sent_count     | req.valid & req.ready
//   res     | out | tokens_ready, in_burst   | res.valid & res.ready
//   cfg     | in  | cfg_index, cfg_data      | cfg_write
//
// one beat per cycle sustained while res.ready is high; a request passes the input
// register, then the bucket update into the output register
// synchronous active-high reset clears bucket, schedule and pipeline valids
// a stalled result holds the output register and the input register behind it;
// ready drops only when both stages are full and res.ready is low
module burst_scheduled_token_bucket #(
  parameter int FRAC_BITS        = bstb_pkg::FRAC_BITS_DEF,
  parameter int TICKS_PER_SECOND = bstb_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bstb_req_if.sink                         req,
  bstb_res_if.source                       res,
  input  logic                             cfg_write,
  input  logic [bstb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bstb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bstb_pkg::*;

  cfg_t               cfg;
  logic               s1_valid;
  logic               s1_type;
  logic [COUNT_W-1:0] s1_sent;
  logic               advance;
  logic [COUNT_W-1:0] core_tokens;
  logic               core_burst;
  logic               out_valid;
  logic [COUNT_W-1:0] out_tokens;
  logic               out_burst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_enable   <= 1'b0;
      cfg.burst_interval <= BURST_INTERVAL_RST;
      cfg.burst_duration <= BURST_DURATION_RST;
      cfg.normal_rate    <= NORMAL_RATE_RST;
      cfg.burst_rate     <= BURST_RATE_RST;
      cfg.max_batch      <= MAX_BATCH_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_BURST_ENABLE:   cfg.burst_enable   <= cfg_data[0];
        REG_BURST_INTERVAL: cfg.burst_interval <= cfg_data;
        REG_BURST_DURATION: cfg.burst_duration <= cfg_data;
        REG_NORMAL_RATE:    cfg.normal_rate    <= cfg_data;
        REG_BURST_RATE:     cfg.burst_rate     <= cfg_data;
        REG_MAX_BATCH:      cfg.max_batch      <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance   = s1_valid && (!out_valid || res.ready);
  assign req.ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_type <= req.req_type;
      s1_sent <= req.sent_count;
    end
  end

  bstb_core #(
    .FRAC_BITS        (FRAC_BITS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .req_type     (s1_type),
    .sent_count   (s1_sent),
    .cfg          (cfg),
    .tokens_ready (core_tokens),
    .in_burst     (core_burst)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tokens <= core_tokens;
      out_burst  <= core_burst;
    end
  end

  assign res.valid        = out_valid;
  assign res.tokens_ready = out_tokens;
  assign res.in_burst     = out_burst;

endmodule

### tb/bstb_grant_monitor.sv
// monitor that predicts and checks every grant beat of the token bucket
module bstb_grant_monitor
  import bstb_pkg::*;
#(
  parameter int FRAC_BITS        = FRAC_BITS_DEF,
  parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  bstb_req_if                    req,
  bstb_res_if                    res,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     errors,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // refill used when a rate register holds zero, never below one lsb
  localparam logic [63:0] FALLBACK_RAW  = (64'd1 << FRAC_BITS) / TICKS_PER_SECOND;
  localparam logic [63:0] FALLBACK_RATE = (FALLBACK_RAW == 0) ? 64'd1 : FALLBACK_RAW;

  typedef struct packed {
    logic [COUNT_W-1:0] tokens;
    logic               in_burst;
  } grant_t;

  // register copies
  logic               cfg_enable;
  logic [31:0]        cfg_interval;
  logic [31:0]        cfg_duration;
  logic [31:0]        cfg_normal_rate;
  logic [31:0]        cfg_burst_rate;
  logic [COUNT_W-1:0] cfg_max_batch;

  // bucket and schedule state
  logic [63:0] bucket_fx;
  logic [31:0] phase_count;
  logic        burst_mode;
  logic        enable_seen;

  grant_t grants_due[$];
  grant_t want;
  grant_t seen;

  // burst schedule, advanced once per tick
  task automatic step_schedule();
    if (!enable_seen && cfg_enable) begin
      phase_count = '0;
      burst_mode  = 1'b0;
    end
    enable_seen = cfg_enable;
    if (cfg_enable) begin
      if (!burst_mode && phase_count >= cfg_interval) begin
        burst_mode  = 1'b1;
        phase_count = '0;
      end else if (burst_mode && phase_count >= cfg_duration) begin
        burst_mode  = 1'b0;
        phase_count = '0;
      end
      if (phase_count != '1) phase_count++;
    end else begin
      burst_mode = 1'b0;
    end
  endtask

  // tick refills and clamps, consume drains with a floor at zero
  task automatic refill_or_drain(input logic kind, input logic [COUNT_W-1:0] count,
                                 output grant_t grant);
    logic [63:0] rate;
    logic [63:0] cap;
    logic [63:0] used;
    logic [63:0] whole;
    if (kind == REQ_TICK) begin
      step_schedule();
      rate = burst_mode ? 64'(cfg_burst_rate) : 64'(cfg_normal_rate);
      if (rate == 0) rate = FALLBACK_RATE;
      cap = (64'(cfg_max_batch) * 2) << FRAC_BITS;
      bucket_fx = bucket_fx + rate;
      if (bucket_fx > cap) bucket_fx = cap;
    end else begin
      used = 64'(count) << FRAC_BITS;
      bucket_fx = (bucket_fx > used) ? bucket_fx - used : 64'd0;
    end
    whole = bucket_fx >> FRAC_BITS;
    if (whole > 64'(cfg_max_batch)) whole = 64'(cfg_max_batch);
    grant.tokens   = whole[COUNT_W-1:0];
    grant.in_burst = burst_mode;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_enable      = 1'b0;
      cfg_interval    = BURST_INTERVAL_RST;
      cfg_duration    = BURST_DURATION_RST;
      cfg_normal_rate = NORMAL_RATE_RST;
      cfg_burst_rate  = BURST_RATE_RST;
      cfg_max_batch   = MAX_BATCH_RST;
      bucket_fx       = '0;
      phase_count     = '0;
      burst_mode      = 1'b0;
      enable_seen     = 1'b0;
      errors          = 0;
      grants_due.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_BURST_ENABLE:   cfg_enable      = cfg_data[0];
          REG_BURST_INTERVAL: cfg_interval    = cfg_data;
          REG_BURST_DURATION: cfg_duration    = cfg_data;
          REG_NORMAL_RATE:    cfg_normal_rate = cfg_data;
          REG_BURST_RATE:     cfg_burst_rate  = cfg_data;
          REG_MAX_BATCH:      cfg_max_batch   = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      // request beat: predict its grant
      if (req.valid && req.ready) begin
        refill_or_drain(req.req_type, req.sent_count, want);
        grants_due.push_back(want);
      end
      // result beat: compare with the oldest grant
      if (res.valid && res.ready) begin
        seen.tokens   = res.tokens_ready;
        seen.in_burst = res.in_burst;
        if (grants_due.size() == 0) begin
          $error("unexpected result beat: tokens_ready %0d, in_burst %0d",
                 seen.tokens, seen.in_burst);
          errors++;
        end else begin
          want = grants_due.pop_front();
          if (seen.tokens !== want.tokens) begin
            $error("tokens_ready: expected %0d, actual %0d", want.tokens, seen.tokens);
            errors++;
          end
          if (seen.in_burst !== want.in_burst) begin
            $error("in_burst: expected %0d, actual %0d", want.in_burst, seen.in_burst);
            errors++;
          end
        end
      end
    end
    pending = grants_due.size();
  end

endmodule

### tb/tb.sv
// top of the token bucket testbench: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bstb_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int STALL_LIMIT  = 1000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     grants_pending;
  logic                   send_idle = 1'b0;
  logic                   recv_idle = 1'b0;

  bstb_req_if req_ch ();
  bstb_res_if res_ch ();

  burst_scheduled_token_bucket i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bstb_grant_monitor i_grant_mon (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .res       (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (fail_count),
    .pending   (grants_pending)
  );

  always #5ns clk = ~clk;

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_TICK;
    req_ch.sent_count = '0;
    res_ch.ready      = 1'b0;
  end

  // one register write, write enable dropped at the next falling edge
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // one request beat after a random gap; valid stays up if no gap follows
  task automatic send_beat(input logic kind, input logic [COUNT_W-1:0] count);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.sent_count <= count;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // stop sending and wait until every grant has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (grants_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return '1;
      2:       return $urandom;
      3:       return $urandom_range(1, 'h400);
      default: return $urandom_range('h2000, 'h30000);
    endcase
  endfunction

  // result side: random stalls, with stretches of none
  initial begin
    int stall;
    int beats_taken;
    beats_taken = 0;
    forever begin
      stall = recv_idle ? $urandom_range(0, 9) : 0;
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      beats_taken++;
      if (beats_taken % 50 == 0) recv_idle = ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog: too long with no beat on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // stimulus
  initial begin
    int sent;
    int phase_len;
    sent = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // defaults: one token per tick, batch of one; empty bucket, clamp, big drain
    send_beat(REQ_CONSUME, 16'd0);
    send_beat(REQ_TICK, 16'd0);
    send_beat(REQ_TICK, 16'd0);
    send_beat(REQ_TICK, 16'd0);
    send_beat(REQ_CONSUME, 16'hFFFF);
    send_beat(REQ_TICK, 16'd0);
    drain();

    // widest batch, top rate, fallback burst rate, mode flips every tick
    write_reg(REG_MAX_BATCH, 32'hFFFF);
    write_reg(REG_NORMAL_RATE, 32'hFFFF_FFFF);
    write_reg(REG_BURST_RATE, 32'd0);
    write_reg(REG_BURST_INTERVAL, 32'd0);
    write_reg(REG_BURST_DURATION, 32'd0);
    write_reg(REG_BURST_ENABLE, 32'd1);
    repeat (4) send_beat(REQ_TICK, 16'd0);
    send_beat(REQ_CONSUME, 16'h8000);
    send_beat(REQ_CONSUME, 16'd1);
    send_beat(REQ_TICK, 16'hFFFF);
    drain();

    // disable, then a fresh rising edge of enable restarts the schedule
    write_reg(REG_BURST_ENABLE, 32'd0);
    write_reg(REG_BURST_INTERVAL, 32'd2);
    write_reg(REG_BURST_DURATION, 32'd1);
    write_reg(REG_NORMAL_RATE, 32'd0);
    write_reg(REG_BURST_RATE, 32'h0001_8000);
    write_reg(REG_MAX_BATCH, 32'd3);
    send_beat(REQ_TICK, 16'd0);
    drain();
    write_reg(REG_BURST_ENABLE, 32'd1);
    repeat (5) send_beat(REQ_TICK, 16'd0);
    drain();

    // capacity lowered under a full bucket, then zero capacity
    write_reg(REG_MAX_BATCH, 32'd1);
    send_beat(REQ_CONSUME, 16'd0);
    send_beat(REQ_TICK, 16'd0);
    drain();
    write_reg(REG_MAX_BATCH, 32'd0);
    send_beat(REQ_TICK, 16'd0);
    send_beat(REQ_CONSUME, 16'd0);
    drain();

    // random phases, each with its own settings
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) write_reg(REG_BURST_ENABLE, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) write_reg(REG_BURST_INTERVAL, pick_span());
      if ($urandom_range(0, 1)) write_reg(REG_BURST_DURATION, pick_span());
      if ($urandom_range(0, 1)) write_reg(REG_NORMAL_RATE, pick_rate());
      if ($urandom_range(0, 1)) write_reg(REG_BURST_RATE, pick_rate());
      case ($urandom_range(0, 5))
        0:       write_reg(REG_MAX_BATCH, 32'hFFFF);
        1:       write_reg(REG_MAX_BATCH, $urandom_range(1, 65535));
        2, 3:    write_reg(REG_MAX_BATCH, $urandom_range(1, 12));
        default: ;
      endcase
      send_idle = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 120);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 6) begin
          send_beat(REQ_TICK, COUNT_W'($urandom));
        end else begin
          case ($urandom_range(0, 7))
            0:       send_beat(REQ_CONSUME, COUNT_W'($urandom_range(0, 65535)));
            1:       send_beat(REQ_CONSUME, 16'hFFFF);
            default: send_beat(REQ_CONSUME, COUNT_W'($urandom_range(0, 8)));
          endcase
        end
        sent++;
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && grants_pending == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
